FILE: rtl/core/icte_pkg.sv
// Shared types, constants and the ones' complement adder for the checksum engine.
package icte_pkg;

  localparam int WordW   = 16;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);

  localparam logic [WordW-1:0] HdrBytes   = 16'd20;
  localparam logic [WordW-1:0] HdrWords   = 16'd10;
  localparam logic [WordW-1:0] IpCsumPos  = 16'd5;
  localparam logic [WordW-1:0] PseudoPos  = 16'd6;
  localparam logic [WordW-1:0] TcpCsumPos = 16'd18;
  localparam logic [WordW-1:0] LenPos     = 16'd1;
  localparam logic [WordW-1:0] ProtoTcp   = 16'd6;
  localparam logic [WordW-1:0] PosMax     = 16'hffff;
  localparam logic [WordW-1:0] HighByte   = 16'hff00;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SHORT   = 2'd1;
  localparam logic [1:0] STATUS_LEN_LOW = 2'd2;

  typedef struct packed {
    logic [WordW-1:0] packet_word;
    logic             last_word;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] ip_checksum;
    logic [WordW-1:0] tcp_checksum;
    logic [1:0]       status;
  } out_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [WordW-1:0] hdr_val;
    logic [WordW-1:0] seg_val;
    logic             last;
    logic [1:0]       status;
    logic [WordW-1:0] len_term;
  } work_t;

  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] s;
    logic [WordW:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[WordW-1:0]} + {{WordW{1'b0}}, s[WordW]};
    return f[WordW-1:0];
  endfunction

endpackage

FILE: rtl/core/icte_front.sv
// Front end: tracks the word position and total length and classifies each word.
module icte_front (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  icte_pkg::in_t   word,
  output icte_pkg::work_t item
);
  import icte_pkg::*;

  logic [WordW-1:0] pos;
  logic [WordW-1:0] total_length;
  logic [WordW-1:0] tl_eff;
  logic [WordW:0]   pos2;
  logic [WordW:0]   received;
  logic [WordW-1:0] half;
  logic [WordW-1:0] needed;
  logic [WordW:0]   tl_round;

  always_comb begin
    tl_eff   = (pos == LenPos) ? word.packet_word : total_length;
    pos2     = {pos, 1'b0};
    received = {1'b0, pos} + 17'd1;
    tl_round = {1'b0, tl_eff} + 17'd1;
    half     = tl_round[WordW:1];
    needed   = (half < HdrWords) ? HdrWords : half;

    item.hdr_val = '0;
    item.seg_val = '0;
    if (pos < HdrWords) begin
      if (pos != IpCsumPos) item.hdr_val = word.packet_word;
      if (pos >= PseudoPos) item.seg_val = word.packet_word;
    end else if (pos != PosMax && pos2 < {1'b0, tl_eff}) begin
      item.seg_val = word.packet_word;
      if (pos2 + 17'd1 == {1'b0, tl_eff}) item.seg_val = word.packet_word & HighByte;
      if (pos == TcpCsumPos) item.seg_val = '0;
    end

    item.last = word.last_word;
    priority if (received < {1'b0, needed}) begin
      item.status = STATUS_SHORT;
    end else if (tl_eff < HdrBytes) begin
      item.status = STATUS_LEN_LOW;
    end else begin
      item.status = STATUS_OK;
    end
    // TCP length plus the protocol number for the pseudo header.
    item.len_term = (tl_eff >= HdrBytes) ? (tl_eff - HdrBytes + ProtoTcp) : ProtoTcp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      total_length <= '0;
    end else if (accept) begin
      if (word.last_word) begin
        pos          <= '0;
        total_length <= '0;
      end else begin
        if (pos != PosMax) pos <= pos + 16'd1;
        if (pos == LenPos) total_length <= word.packet_word;
      end
    end
  end

endmodule

FILE: rtl/core/icte_queue.sv
// Short first-in first-out queue of classified words between front and back.
module icte_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  icte_pkg::work_t wr_data,
  output logic            full,
  input  logic            rd,
  output icte_pkg::work_t rd_data,
  output logic            empty
);
  import icte_pkg::*;

  work_t            slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;

  assign full    = (count == (QPtrW+1)'(QDepth));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/icte_back.sv
// Back end: accumulates both checksums and fills the result register.
module icte_back (
  input  logic            clk,
  input  logic            rst,
  input  icte_pkg::work_t item,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output icte_pkg::out_t  result
);
  import icte_pkg::*;

  logic [WordW-1:0] header_sum;
  logic [WordW-1:0] segment_sum;
  logic [WordW-1:0] hdr_next;
  logic [WordW-1:0] seg_next;
  logic [WordW-1:0] seg_final;
  logic             out_valid;
  out_t             out_reg;

  assign empty  = !out_valid;
  assign result = out_reg;
  assign q_pop  = !q_empty && (!item.last || !out_valid || pop);

  always_comb begin
    hdr_next  = oc_add(header_sum, item.hdr_val);
    seg_next  = oc_add(segment_sum, item.seg_val);
    seg_final = oc_add(seg_next, item.len_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_sum  <= '0;
      segment_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (q_pop) begin
        if (item.last) begin
          header_sum  <= '0;
          segment_sum <= '0;
          out_valid   <= 1'b1;
        end else begin
          header_sum  <= hdr_next;
          segment_sum <= seg_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && item.last) begin
      out_reg.ip_checksum  <= ~hdr_next;
      out_reg.tcp_checksum <= (item.status == STATUS_LEN_LOW) ? '0 : ~seg_final;
      out_reg.status       <= item.status;
    end
  end

endmodule

FILE: rtl/core/ipv4_tcp_checksum_engine.sv
// Top level of the IPv4/TCP checksum engine.
//
//   Channel   Direction  Handshake         Payload
//   word      in         push / full       packet_word, last_word
//   result    out        pop / empty       ip_checksum, tcp_checksum, status
//
// One packet word is taken every cycle while full is low; the front end
// classifies it in the same cycle and writes it into a four-entry queue.
// The back end takes one queued word per cycle while the queue holds one;
// a last word passes through its queue slot and then the result register.
// The synchronous reset empties the queue, clears both sums and drops any waiting result.
// An unpopped result halts the back end at the next last word, which waits
// at the head of the queue; three further words then fill it and raise full.
module ipv4_tcp_checksum_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  icte_pkg::in_t  word,
  output logic           empty,
  input  logic           pop,
  output icte_pkg::out_t result
);
  import icte_pkg::*;

  // A transaction on the input side is taken only when the queue has room.
  logic  accept;
  work_t front_item;
  work_t back_item;
  logic  q_empty;
  logic  q_pop;

  assign accept = push && !full;

  // The front end keeps the word position and the captured total length.
  icte_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (word),
    .item   (front_item)
  );

  // The queue decouples classification from accumulation.
  icte_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (front_item),
    .full    (full),
    .rd      (q_pop),
    .rd_data (back_item),
    .empty   (q_empty)
  );

  // The back end sums the words and holds the finished result.
  icte_back u_back (
    .clk     (clk),
    .rst     (rst),
    .item    (back_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // The back end never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // A waiting result carries a defined status code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status == STATUS_OK || result.status == STATUS_SHORT ||
                result.status == STATUS_LEN_LOW))
    else $error("undefined status code");

  // A result with status LEN_LOW (length under twenty bytes) gives a zero TCP checksum.
  a_len_low_tcp: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == STATUS_LEN_LOW) |-> result.tcp_checksum == '0)
    else $error("non-zero TCP checksum with short total length");

  // A result waiting while the back end meets a new last word is not overwritten.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(result))
    else $error("waiting result lost or changed");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the IPv4/TCP checksum engine.
`timescale 1ns / 1ps

module tb;
  import icte_pkg::*;

  // Clock, reset and the two queue-like ports of the engine.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t  word = '0;
  logic empty;
  logic pop = 1'b0;
  out_t result;

  // Checksum prediction state, mirroring what the engine keeps per packet.
  int unsigned      word_index = 0;
  logic [WordW-1:0] hdr_sum = '0;
  logic [WordW-1:0] seg_sum = '0;
  logic [WordW-1:0] ip_total_len = '0;

  // Predicted results waiting for the engine, oldest first.
  out_t pending_results[$];

  int error_count = 0;

  // Idling controls. The sender moves words in bursts; the receiver stalls
  // for random stretches whose length is set by stall_max.
  int burst_left = 1;
  int gap_max = 0;
  int stall_max = 0;
  int stall_left = 0;

  ipv4_tcp_checksum_engine i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .word  (word),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Ones' complement addition with the carry folded back into bit 0.
  function automatic logic [WordW-1:0] fold_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [31:0] s;
    s = {16'h0, a} + {16'h0, b};
    s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    return s[15:0];
  endfunction

  // Updates the running sums for one accepted word and, when the word
  // closes the packet, queues the checksums and status the engine owes us.
  function automatic void predict_checksums(input in_t item);
    int unsigned      pos;
    int unsigned      len32;
    int unsigned      needed;
    int unsigned      tcp_len;
    logic [WordW-1:0] value;
    out_t             r;
    pos = word_index;
    len32 = 32'(ip_total_len);
    if (pos < 32'(HdrWords)) begin
      if (pos == 32'(LenPos)) begin
        ip_total_len = item.packet_word;
        len32 = 32'(item.packet_word);
      end
      if (pos != 32'(IpCsumPos)) hdr_sum = fold_add(hdr_sum, item.packet_word);
      if (pos >= 32'(PseudoPos)) seg_sum = fold_add(seg_sum, item.packet_word);
    end else if (pos < 32'(PosMax) && 2 * pos < len32) begin
      value = item.packet_word;
      // An odd total length leaves a lone byte in the upper half of the
      // final word; the lower half is padding and counts as zero.
      if (2 * pos + 1 == len32) value = value & HighByte;
      if (pos == 32'(TcpCsumPos)) value = '0;
      seg_sum = fold_add(seg_sum, value);
    end
    if (word_index < 32'(PosMax)) word_index++;
    if (!item.last_word) return;

    needed = (len32 + 1) >> 1;
    if (needed < 32'(HdrWords)) needed = 32'(HdrWords);
    if (pos + 1 < needed) r.status = STATUS_SHORT;
    else if (len32 < 32'(HdrBytes)) r.status = STATUS_LEN_LOW;
    else r.status = STATUS_OK;

    r.ip_checksum = ~hdr_sum;
    if (r.status == STATUS_LEN_LOW) begin
      r.tcp_checksum = '0;
    end else begin
      tcp_len = (len32 >= 32'(HdrBytes)) ? len32 - 32'(HdrBytes) : 0;
      r.tcp_checksum = ~fold_add(seg_sum, 16'(tcp_len + 32'(ProtoTcp)));
    end
    pending_results.push_back(r);

    word_index = 0;
    hdr_sum = '0;
    seg_sum = '0;
    ip_total_len = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Compares one popped result, field by field, with the oldest prediction.
  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result ip=%h tcp=%h status=%0d with nothing expected",
                                got.ip_checksum, got.tcp_checksum, got.status));
      return;
    end
    want = pending_results.pop_front();
    if (got.ip_checksum !== want.ip_checksum)
      report_mismatch($sformatf("ip_checksum %h, expected %h",
                                got.ip_checksum, want.ip_checksum));
    if (got.tcp_checksum !== want.tcp_checksum)
      report_mismatch($sformatf("tcp_checksum %h, expected %h",
                                got.tcp_checksum, want.tcp_checksum));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
  endtask

  // Both handshakes are sampled at the rising edge, before any of this
  // edge's nonblocking updates land, so the pre-edge values decide whether
  // a transaction took place. A result can never leave in the cycle its
  // last word arrives, so the order of the two checks does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) check_result(result);
      if (push && !full) predict_checksums(word);
    end
  end

  // The receiver's own stall pattern: mostly ready, with occasional stalls
  // whose length is bounded by stall_max (zero switches stalls off).
  always @(posedge clk) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_max > 0 && $urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(1, stall_max);
    end else begin
      pop <= 1'b1;
    end
  end

  // Offers one word and waits for the transaction. When a burst runs out
  // the sender may drop push for a random gap; apart from the end of the run,
  // push is only lowered here, so it never gets two assignments in one time step.
  task automatic send_word(input logic [WordW-1:0] value, input logic is_last);
    push <= 1'b1;
    word <= '{packet_word: value, last_word: is_last};
    do @(posedge clk); while (full);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic send_packet(input logic [WordW-1:0] words[$]);
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  // A packet of a single all-ones word: far too short, and word 0 at its
  // largest value.
  task automatic test_single_word();
    logic [WordW-1:0] pkt[$];
    pkt = '{16'hffff};
    send_packet(pkt);
  endtask

  // A full ten-word header that claims a total length of zero. The header
  // checksum is still due, the TCP checksum must come back as zero.
  task automatic test_length_under_twenty();
    logic [WordW-1:0] pkt[$];
    pkt = '{16'h4500, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff};
    send_packet(pkt);
  endtask

  // Total length 21: word 10 carries one real byte and one pad byte, and
  // word 11 lies past the end and must be left out of both sums.
  task automatic test_odd_tail_and_overrun();
    logic [WordW-1:0] pkt[$];
    for (int i = 0; i < 12; i++) pkt.push_back(16'hffff);
    pkt[1] = 16'd21;
    send_packet(pkt);
  endtask

  // Mostly well-formed packets with random content and random lengths,
  // mixed with short packets, packets that run on past their length,
  // headers claiming less than twenty bytes and wild length fields.
  task automatic test_random_packets();
    logic [WordW-1:0] pkt[$];
    int unsigned tlen;
    int unsigned needed;
    int unsigned nwords;
    int kind;
    int fill;
    int useful_words;
    int packets;
    useful_words = 0;
    packets = 0;
    while (useful_words < 850 || packets < 40) begin
      // Change the idling pattern every few packets; zero on either side
      // gives stretches that run flat out.
      if (packets % 6 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_max = 0;
          1: gap_max = 0;
          2: gap_max = 2;
          default: gap_max = 6;
        endcase
        case ($urandom_range(0, 3))
          0: stall_max <= 0;
          1: stall_max <= 0;
          2: stall_max <= 3;
          default: stall_max <= 12;
        endcase
      end
      kind = $urandom_range(0, 99);
      if (kind < 96) begin
        tlen = ($urandom_range(0, 4) == 0) ? $urandom_range(61, 120)
                                            : $urandom_range(20, 60);
      end else begin
        tlen = $urandom_range(0, 65535);
      end
      needed = (tlen + 1) / 2;
      if (needed < 32'(HdrWords)) needed = 32'(HdrWords);
      if (kind < 70) begin
        nwords = needed;
      end else if (kind < 80) begin
        nwords = $urandom_range(1, needed - 1);
      end else if (kind < 88) begin
        nwords = needed + $urandom_range(1, 4);
      end else if (kind < 96) begin
        tlen = $urandom_range(0, 19);
        nwords = $urandom_range(10, 13);
        needed = 10;
      end else begin
        nwords = $urandom_range(1, 14);
      end
      fill = $urandom_range(0, 7);
      pkt.delete();
      for (int unsigned i = 0; i < nwords; i++) begin
        if (fill == 0) pkt.push_back(16'hffff);
        else pkt.push_back(16'($urandom_range(0, 65535)));
      end
      if (nwords > 1) pkt[1] = 16'(tlen);
      send_packet(pkt);
      useful_words += (nwords < needed) ? nwords : needed;
      packets++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_max = 2;
    stall_max <= 3;
    test_single_word();
    test_length_under_twenty();
    test_odd_tail_and_overrun();
    test_random_packets();
    push <= 1'b0;

    // Let the last results drain, then keep watching for anything the
    // engine might still produce without being asked.
    stall_max <= 2;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("** ipv4_tcp_checksum_engine: PASSED **");
    end else begin
      $display("** ipv4_tcp_checksum_engine: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("** ipv4_tcp_checksum_engine: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/icte_pkg.sv
rtl/core/icte_front.sv
rtl/core/icte_queue.sv
rtl/core/icte_back.sv
rtl/core/ipv4_tcp_checksum_engine.sv
verif/tb.sv
